// ----- rtl/stac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stac_pkg
// Shared types, constants and helpers of the touch-screen ADC serial slave.
// ----------------------------------------------------------------------------
package stac_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 12;

    localparam int NUM_REGS     = 8;
    localparam int REG_IDX_W    = 3;
    localparam int READING_W    = 12;
    localparam int CH_W         = 3;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int CMD_W        = 8;
    localparam int CMD_CNT_W    = 4;
    localparam int BR_W         = $clog2(SAMPLE_BITS + 1);
    localparam int SHORT_BITS   = 8;
    localparam int COPY_W       = (READING_W < SAMPLE_BITS) ? READING_W : SAMPLE_BITS;

    localparam int CMD_CH_LSB   = 4;
    localparam int CMD_MODE_BIT = 3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_CMD    = 2'd1,
        PH_RESULT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CH_W-1:0] last_channel;
        logic            dout_bit;
        logic            dout_driven;
    } result_t;

    // Fits a stored reading to the sample width: low bits kept, high bits zero.
    function automatic logic [SAMPLE_BITS-1:0] fit_sample(input logic [READING_W-1:0] rd);
        logic [SAMPLE_BITS-1:0] v;
        v = '0;
        for (int i = 0; i < COPY_W; i++)
        begin
            v[i] = rd[i];
        end
        return v;
    endfunction

endpackage

// ----- rtl/stac_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stac_regs
// Per-channel reading registers with a write port and one read port.
// ----------------------------------------------------------------------------
module stac_regs
    import stac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [READING_W-1:0] wr_data,
    input  logic [CH_W-1:0]      rd_channel,
    output logic [READING_W-1:0] rd_data
);

    logic [READING_W-1:0] reading_reg [NUM_CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                reading_reg[i] <= '0;
            end
        end
        else if (wr_en && (int'(wr_index) < NUM_CHANNELS))
        begin
            reading_reg[wr_index[CH_IDX_W-1:0]] <= wr_data;
        end
    end

    // A channel with no register reads as zero.
    always_comb
    begin
        if (int'(rd_channel) < NUM_CHANNELS)
        begin
            rd_data = reading_reg[rd_channel[CH_IDX_W-1:0]];
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

// ----- rtl/stac_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stac_core
// Pin-sample protocol engine: select and clock edge handling, command capture
// and result shift-out, one sample per transfer.
// ----------------------------------------------------------------------------
module stac_core
    import stac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 cs_level,
    input  logic                 clk_level,
    input  logic                 din_level,
    output logic [CH_W-1:0]      rd_channel,
    input  logic [READING_W-1:0] rd_data,
    output result_t              result
);

    logic                   prev_select_reg, prev_select_next;
    logic                   prev_clock_reg,  prev_clock_next;
    phase_t                 phase_reg,       phase_next;
    logic [CMD_CNT_W-1:0]   cmd_cnt_reg,     cmd_cnt_next;
    logic [CMD_W-1:0]       cmd_shift_reg,   cmd_shift_next;
    logic [CH_W-1:0]        sel_ch_reg,      sel_ch_next;
    logic [BR_W-1:0]        bits_rem_reg,    bits_rem_next;
    logic [SAMPLE_BITS-1:0] res_shift_reg,   res_shift_next;
    logic                   out_level_reg,   out_level_next;

    logic                   rising;
    logic                   falling;
    logic [CMD_W-1:0]       cmd_base;
    logic [CMD_W-1:0]       cmd_new;
    logic [SAMPLE_BITS-1:0] sample_full;
    logic [SAMPLE_BITS-1:0] sample_sel;
    logic [BR_W-1:0]        bits_sel;
    logic [SAMPLE_BITS-1:0] sel_tap;
    logic [BR_W-1:0]        bits_dec;
    logic [SAMPLE_BITS-1:0] run_tap;

    assign rising  = clk_level & ~prev_clock_reg;
    assign falling = ~clk_level & prev_clock_reg;

    // A falling select clears the command byte before the new bit is shifted in.
    assign cmd_base = (!cs_level && prev_select_reg) ? '0 : cmd_shift_reg;

    // The completed command byte picks the channel straight away.
    assign cmd_new    = {cmd_base[CMD_W-2:0], din_level};
    assign rd_channel = cmd_new[CMD_CH_LSB +: CH_W];

    always_comb
    begin
        sample_full = fit_sample(rd_data);
        if (cmd_new[CMD_MODE_BIT])
        begin
            sample_sel = sample_full >> (SAMPLE_BITS - SHORT_BITS);
            bits_sel   = BR_W'(SHORT_BITS);
        end
        else
        begin
            sample_sel = sample_full;
            bits_sel   = BR_W'(SAMPLE_BITS);
        end
        sel_tap  = sample_sel >> (bits_sel - BR_W'(1));
        bits_dec = bits_rem_reg - BR_W'(1);
        run_tap  = res_shift_reg >> (bits_dec - BR_W'(1));
    end

    always_comb
    begin
        prev_select_next = cs_level;
        prev_clock_next  = clk_level;
        phase_next       = phase_reg;
        cmd_cnt_next     = cmd_cnt_reg;
        cmd_shift_next   = cmd_shift_reg;
        sel_ch_next      = sel_ch_reg;
        bits_rem_next    = bits_rem_reg;
        res_shift_next   = res_shift_reg;
        out_level_next   = out_level_reg;

        if (!cs_level && prev_select_reg)
        begin
            phase_next     = PH_CMD;
            cmd_cnt_next   = '0;
            cmd_shift_next = '0;
        end
        if (cs_level && !prev_select_reg)
        begin
            phase_next = PH_IDLE;
        end

        if (!cs_level)
        begin
            if (rising && (phase_next == PH_CMD))
            begin
                cmd_cnt_next   = cmd_cnt_next + CMD_CNT_W'(1);
                cmd_shift_next = cmd_new;
                if (cmd_cnt_next >= CMD_CNT_W'(CMD_W))
                begin
                    sel_ch_next    = rd_channel;
                    bits_rem_next  = bits_sel;
                    res_shift_next = sample_sel;
                    out_level_next = sel_tap[0];
                    phase_next     = PH_RESULT;
                end
            end
            else if (falling && (phase_next == PH_RESULT))
            begin
                // Once the reading is used up the count stays at zero and the
                // output bit holds.
                if (bits_rem_reg != '0)
                begin
                    bits_rem_next = bits_dec;
                    if (bits_dec != '0)
                    begin
                        out_level_next = run_tap[0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_select_reg <= 1'b1;
            prev_clock_reg  <= 1'b0;
            phase_reg       <= PH_IDLE;
            cmd_cnt_reg     <= '0;
            cmd_shift_reg   <= '0;
            sel_ch_reg      <= '0;
            bits_rem_reg    <= '0;
            res_shift_reg   <= '0;
            out_level_reg   <= 1'b0;
        end
        else if (step)
        begin
            prev_select_reg <= prev_select_next;
            prev_clock_reg  <= prev_clock_next;
            phase_reg       <= phase_next;
            cmd_cnt_reg     <= cmd_cnt_next;
            cmd_shift_reg   <= cmd_shift_next;
            sel_ch_reg      <= sel_ch_next;
            bits_rem_reg    <= bits_rem_next;
            res_shift_reg   <= res_shift_next;
            out_level_reg   <= out_level_next;
        end
    end

    always_comb
    begin
        result.dout_driven  = (phase_next == PH_RESULT);
        result.dout_bit     = (phase_next == PH_RESULT) & out_level_next;
        result.last_channel = sel_ch_next;
    end

endmodule

// ----- rtl/spi_touch_adc_slave.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_touch_adc_slave
// Serial slave of a touch-screen ADC, driven by a stream of pin samples.
// ----------------------------------------------------------------------------
// Timing: a result appears on the master side in the cycle after its sample
// transfer. Throughput: one sample per cycle while no result stalls; the protocol
// state and the output register are both updated in the same cycle as the transfer.
// Reset: asynchronous, active low; clears the protocol state, the output
// register's valid flag and all channel readings to zero.
// ----------------------------------------------------------------------------
module spi_touch_adc_slave
    import stac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // cs_level, clk_level, din_level, zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // dout_driven, dout_bit, last_channel[2:0], zero fill
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [READING_W-1:0] cfg_data
);

    logic                 accept;
    logic [CH_W-1:0]      rd_channel;
    logic [READING_W-1:0] rd_data;
    result_t              result;
    result_t              out_reg;
    logic                 m_valid_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_valid_reg | m_tready;
    assign accept    = s_tvalid & s_tready;

    stac_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg_valid & cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .rd_channel (rd_channel),
        .rd_data    (rd_data)
    );

    stac_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .cs_level   (s_tdata[0]),
        .clk_level  (s_tdata[1]),
        .din_level  (s_tdata[2]),
        .rd_channel (rd_channel),
        .rd_data    (rd_data),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

    // Every sample transfer leaves a result waiting.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("sample transfer produced no result");

    // A held result is never overwritten by a new sample.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("sample accepted while result stalled");

    // The data-out bit is only set while the result phase drives it.
    a_bit_driven: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("data-out bit set while not driven");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch-screen ADC serial slave. Pin samples are
// streamed in as one short directed frame and then random command frames. The
// frames are mixed with noise and cut-short selects. Every response is checked
// against a model of the serial protocol kept in the bench, or the directed
// frame's fixed rows. The channel readings are reloaded between runs of samples.
// ----------------------------------------------------------------------------
module tb_top;
    import stac_pkg::*;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int ITEMS_PER_SETTING = 450;
    localparam int NUM_SETTINGS      = 3;
    localparam int DIRECTED_LEN      = 25;

    typedef enum int {
        REG_CH0, REG_CH1, REG_CH2, REG_CH3, REG_CH4, REG_CH5, REG_CH6, REG_CH7
    } reading_reg_t;

    typedef struct packed {
        logic    cs;
        logic    sck;
        logic    din;
        logic    typed;
        result_t want;
    } pin_row_t;

    localparam result_t QUIET_CH0 = '{last_channel: 3'd0, dout_bit: 1'b0, dout_driven: 1'b0};
    localparam result_t QUIET_CH5 = '{last_channel: 3'd5, dout_bit: 1'b0, dout_driven: 1'b0};
    localparam result_t FROM_MODEL = '0;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;  // cs_level, clk_level, din_level, zero fill
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;         // dout_driven, dout_bit, last_channel[2:0], zero fill
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [READING_W-1:0] cfg_data  = '0;

    // Model state of the serial protocol, at its reset values.
    logic                   pr_select    = 1'b1;
    logic                   pr_sck       = 1'b0;
    phase_t                 pr_phase     = PH_IDLE;
    logic [CMD_CNT_W-1:0]   pr_cmd_count = '0;
    logic [CMD_W-1:0]       pr_cmd       = '0;
    logic [CH_W-1:0]        pr_channel   = '0;
    logic [BR_W-1:0]        pr_bits_left = '0;
    logic [SAMPLE_BITS-1:0] pr_shift     = '0;
    logic                   pr_out       = 1'b0;
    logic [READING_W-1:0]   pr_readings [NUM_REGS] = '{default: '0};

    logic [READING_W-1:0]   reading_plan [NUM_REGS];
    pin_row_t               pin_samples [$];
    result_t                pending_responses [$];
    pin_row_t               cur_row = '0;

    int cycles    = 0;
    int n_samples = 0;
    int n_checked = 0;
    int n_errors  = 0;
    int n_frames  = 0;
    int rx_kind   = 0;
    int rx_left   = 0;

    // Directed frame: command 1101_0101 selects channel 5 in full mode, with
    // unused bits 7, 2 and 0 set. Typed rows are the obvious quiet outputs.
    pin_row_t directed_rows [DIRECTED_LEN] = '{
        '{1'b1, 1'b1, 1'b1, 1'b1, QUIET_CH0},   // clock wiggles while deselected
        '{1'b1, 1'b0, 1'b0, 1'b1, QUIET_CH0},
        '{1'b0, 1'b0, 1'b1, 1'b1, QUIET_CH0},   // select falls
        '{1'b0, 1'b1, 1'b1, 1'b1, QUIET_CH0},   // bit 7, ignored
        '{1'b0, 1'b0, 1'b0, 1'b1, QUIET_CH0},
        '{1'b0, 1'b1, 1'b1, 1'b1, QUIET_CH0},   // channel bits 1, 0, 1
        '{1'b0, 1'b0, 1'b0, 1'b1, QUIET_CH0},
        '{1'b0, 1'b1, 1'b0, 1'b1, QUIET_CH0},
        '{1'b0, 1'b0, 1'b1, 1'b1, QUIET_CH0},
        '{1'b0, 1'b1, 1'b1, 1'b1, QUIET_CH0},
        '{1'b0, 1'b0, 1'b0, 1'b1, QUIET_CH0},
        '{1'b0, 1'b1, 1'b0, 1'b1, QUIET_CH0},   // full 12-bit mode
        '{1'b0, 1'b0, 1'b1, 1'b1, QUIET_CH0},
        '{1'b0, 1'b1, 1'b1, 1'b1, QUIET_CH0},   // bits 2..0, ignored
        '{1'b0, 1'b0, 1'b0, 1'b1, QUIET_CH0},
        '{1'b0, 1'b1, 1'b0, 1'b1, QUIET_CH0},
        '{1'b0, 1'b0, 1'b1, 1'b1, QUIET_CH0},
        '{1'b0, 1'b1, 1'b1, 1'b0, FROM_MODEL},  // eighth rising edge loads the reading
        '{1'b0, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 1'b1, 1'b1, 1'b0, FROM_MODEL},
        '{1'b0, 1'b0, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 1'b1, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 1'b0, 1'b1, 1'b0, FROM_MODEL},
        '{1'b1, 1'b0, 1'b0, 1'b1, QUIET_CH5},   // deselect returns to idle
        '{1'b1, 1'b1, 1'b0, 1'b1, QUIET_CH5}
    };

    spi_touch_adc_slave i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Advances the protocol model by one pin sample and returns its response.
    function automatic result_t predict_pin_response(input logic cs, input logic sck,
                                                     input logic din);
        result_t                r;
        logic                   rising;
        logic                   falling;
        logic [SAMPLE_BITS-1:0] value;
        rising  = sck && !pr_sck;
        falling = !sck && pr_sck;
        if (!cs && pr_select)
        begin
            pr_phase     = PH_CMD;
            pr_cmd_count = '0;
            pr_cmd       = '0;
        end
        if (cs && !pr_select)
            pr_phase = PH_IDLE;
        pr_select = cs;
        if (!cs && rising && pr_phase == PH_CMD)
        begin
            pr_cmd       = {pr_cmd[CMD_W-2:0], din};
            pr_cmd_count = pr_cmd_count + 1'b1;
            if (pr_cmd_count >= CMD_W)
            begin
                pr_channel = pr_cmd[CMD_CH_LSB +: CH_W];
                value = (pr_channel < NUM_CHANNELS) ? pr_readings[pr_channel] : '0;
                if (pr_cmd[CMD_MODE_BIT])
                begin
                    value        = value >> (SAMPLE_BITS - SHORT_BITS);
                    pr_bits_left = BR_W'(SHORT_BITS);
                end
                else
                begin
                    pr_bits_left = BR_W'(SAMPLE_BITS);
                end
                pr_shift = value;
                pr_phase = PH_RESULT;
                pr_out   = pr_shift[pr_bits_left - 1];
            end
        end
        else if (!cs && falling && pr_phase == PH_RESULT && pr_bits_left != 0)
        begin
            // Once the reading is used up the output level simply holds.
            pr_bits_left = pr_bits_left - 1'b1;
            if (pr_bits_left != 0)
                pr_out = pr_shift[pr_bits_left - 1];
        end
        pr_sck = sck;
        r.dout_driven  = (pr_phase == PH_RESULT);
        r.dout_bit     = (pr_phase == PH_RESULT) && pr_out;
        r.last_channel = pr_channel;
        return r;
    endfunction

    function automatic void add_pin(input logic cs, input logic sck, input logic din);
        pin_row_t row;
        row     = '0;
        row.cs  = cs;
        row.sck = sck;
        row.din = din;
        pin_samples.push_back(row);
    endfunction

    // One clock level held over one to four samples while selected; only the first
    // sample of a high level matters for the data-in pin.
    function automatic void add_level(input logic sck, input logic din);
        int hold;
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
        add_pin(1'b0, sck, din);
        repeat (hold - 1) add_pin(1'b0, sck, 1'($urandom));
    endfunction

    function automatic void add_frame();
        logic [CMD_W-1:0] cmd;
        int               kind;
        int               cut;
        int               falls;
        kind = $urandom_range(0, 9);
        n_frames++;
        repeat ($urandom_range(1, 4)) add_pin(1'b1, 1'($urandom), 1'($urandom));
        if (kind == 0)
        begin
            repeat ($urandom_range(4, 24)) add_pin(1'($urandom), 1'($urandom), 1'($urandom));
            return;
        end
        cmd = CMD_W'($urandom);
        // Some frames lose the select part-way through the command byte.
        cut = (kind == 1) ? $urandom_range(0, 2 * CMD_W - 1) : 2 * CMD_W;
        // Now and then the clock rises together with the select.
        add_pin(1'b0, ($urandom_range(0, 7) == 0), 1'($urandom));
        for (int i = 0; i < 2 * CMD_W; i++)
        begin
            if (i == cut)
            begin
                add_pin(1'b1, 1'($urandom), 1'($urandom));
                return;
            end
            add_level(i[0], i[0] ? cmd[CMD_W - 1 - i / 2] : 1'($urandom));
        end
        // Beyond the length of the reading the extra falling edges run it dry.
        falls = $urandom_range(0, 15);
        repeat (falls)
        begin
            add_level(1'b0, 1'($urandom));
            add_level(1'b1, 1'($urandom));
        end
    endfunction

    task automatic load_readings();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= REG_IDX_W'(i);
            cfg_data  <= reading_plan[i];
            do @(posedge clk); while (!cfg_ready);
            pr_readings[i] = reading_plan[i];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Streams the queued pin samples in bursts separated by random gaps.
    task automatic play_samples();
        int       burst;
        int       gap;
        pin_row_t row;
        while (pin_samples.size() > 0)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
            while (burst > 0 && pin_samples.size() > 0)
            begin
                row = pin_samples.pop_front();
                @(negedge clk);
                cur_row  <= row;
                s_tdata  <= {5'b0, row.din, row.sck, row.cs};
                s_tvalid <= 1'b1;
                do @(posedge clk); while (!s_tready);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // The receiver alternates between free-running, light and heavy stalling.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_kind = $urandom_range(0, 2);
            rx_left = $urandom_range(10, 60);
        end
        rx_left--;
        case (rx_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Samples are predicted at the transfer in, responses checked at the
    // transfer out, both from one process so that their order is fixed.
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        result_t got;
        if (s_tvalid && s_tready)
        begin
            want = predict_pin_response(cur_row.cs, cur_row.sck, cur_row.din);
            if (cur_row.typed)
                want = cur_row.want;
            pending_responses.push_back(want);
            n_samples++;
        end
        if (m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_responses.size() == 0)
            begin
                $display("%0t ns: unexpected response, expected none, got %h", $time, got);
                n_errors++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (got.dout_driven !== want.dout_driven)
                begin
                    $display("%0t ns: dout_driven expected %0d, got %0d",
                             $time, want.dout_driven, got.dout_driven);
                    n_errors++;
                end
                if (got.dout_bit !== want.dout_bit)
                begin
                    $display("%0t ns: dout_bit expected %0d, got %0d",
                             $time, want.dout_bit, got.dout_bit);
                    n_errors++;
                end
                if (got.last_channel !== want.last_channel)
                begin
                    $display("%0t ns: last_channel expected %0d, got %0d",
                             $time, want.last_channel, got.last_channel);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int target;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            foreach (reading_plan[i])
                reading_plan[i] = READING_W'($urandom);
            case (s)
                0:
                begin
                    reading_plan[REG_CH0] = '0;
                    reading_plan[REG_CH1] = '1;
                    reading_plan[REG_CH5] = 12'hA5C;   // read by the directed frame
                end
                1:
                begin
                    reading_plan[REG_CH0] = '1;
                    reading_plan[REG_CH7] = '0;
                end
                default:
                begin
                end
            endcase
            load_readings();
            if (s == 0)
            begin
                foreach (directed_rows[i])
                    pin_samples.push_back(directed_rows[i]);
            end
            target = pin_samples.size() + ITEMS_PER_SETTING;
            while (pin_samples.size() < target)
                add_frame();
            play_samples();
            while (pending_responses.size() != 0)
                @(posedge clk);
        end
        repeat (4) @(posedge clk);
        $display("Ran %0d pin samples (%0d random frames) under %0d sets of channel readings.",
                 n_samples, n_frames, NUM_SETTINGS);
        $display("Compared %0d responses, %0d field mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
